// ===== hw/rtl/mvcm_pkg.sv =====
package mvcm_pkg;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        source_chan;
    logic [7:0]        patch;
    logic [7:0]        bank;
    logic [15:0]       pref_mask;
    logic              pref_lock;
    logic [6:0]        key;
    logic [7:0]        volume;
    logic [13:0]       bend_value;
    logic signed [7:0] pan;
  } in_item_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [7:0]  patch;
    logic [7:0]  bank;
    logic [7:0]  pan;
    logic [4:0]  chan;
    logic [16:0] pref;
  } ent_t;

  localparam ent_t ENT_RESET = '{note: 7'd0, patch: 8'd0, bank: 8'd0, pan: 8'd0,
                                 chan: 5'd0, pref: 17'h0FFFF};

  localparam logic [2:0] CMD_PATCH_BANK = 3'd0;
  localparam logic [2:0] CMD_KEY_ON     = 3'd1;
  localparam logic [2:0] CMD_KEY_OFF    = 3'd2;
  localparam logic [2:0] CMD_TOUCH      = 3'd3;
  localparam logic [2:0] CMD_BEND       = 3'd4;
  localparam logic [2:0] CMD_PAN        = 3'd5;

  localparam logic [1:0] CFG_MIDI_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_MODE = 2'd1;

  localparam logic [1:0] MODE_ALWAYS = 2'd0;
  localparam logic [1:0] MODE_TRY    = 2'd1;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [7:0] CC_BANK   = 8'd0;
  localparam logic [7:0] CC_VOLUME = 8'd7;
  localparam logic [7:0] CC_PAN    = 8'd10;

  localparam logic [3:0]  PERC_CHAN   = 4'd9;
  localparam logic [7:0]  UNKNOWN     = 8'hFF;
  localparam logic [13:0] BEND_CENTER = 14'h2000;
  localparam logic [7:0]  VEL_FULL    = 8'd127;
  localparam logic signed [5:0] SCORE_NONE = -6'sd32;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_EXEC, S_MSG, S_SCAN, S_SCORE, S_FLUSH
  } state_e;

  typedef enum logic [1:0] {PH_STATUS, PH_D1, PH_D2} phase_e;

  function automatic logic [7:0] map_volume(input logic [7:0] v);
    map_volume = (v >= 8'd63) ? 8'd127 : {v[6:0], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/mvcm_src_mem.sv =====
module mvcm_src_mem #(
  parameter int NUM_SOURCES = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [$clog2(NUM_SOURCES)-1:0]     waddr_i,
  input  mvcm_pkg::ent_t                     wdata_i,
  input  logic [$clog2(NUM_SOURCES)-1:0]     raddr_i,
  output mvcm_pkg::ent_t                     rdata_o
);
  import mvcm_pkg::*;

  ent_t mem [NUM_SOURCES];
  ent_t rd_q;
  logic [NUM_SOURCES-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i] | (we_i && waddr_i == raddr_i);
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : ENT_RESET;

endmodule

// ===== hw/rtl/midi_voice_channel_mapper.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
// out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// One transaction at a time; the input is stalled until the block is idle again.
// Patch/bank only updates the source entry; touch, bend, pan and key off may emit a message.
// Melodic key on is dominated by the scan of the source memory (one entry a cycle)
// and the score over the 16 channels; percussion key on skips both.
// Reset clears control and valid bits at once; no clearing pass. A stalled
// output holds the byte generator; one byte is held back to mark the last.
module midi_voice_channel_mapper #(
  parameter int NUM_SOURCES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mvcm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mvcm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [1:0]          cfg_data_i
);
  import mvcm_pkg::*;

  localparam int AW = $clog2(NUM_SOURCES);
  localparam int CW = $clog2(NUM_SOURCES + 1);

  state_e state_q, state_d;
  phase_e phase_q;
  in_item_t item_q;
  ent_t e_q, e_d, rdata;
  logic [2:0] step_q;
  logic [3:0] mc_q;
  logic enable_q;
  logic [1:0] mode_q;
  logic [7:0] running_q;

  logic [7:0]  out_vol_q  [16];
  logic [7:0]  out_pat_q  [16];
  logic [7:0]  out_bank_q [16];
  logic [13:0] out_bend_q [16];
  logic [7:0]  out_pan_q  [16];

  logic [CW-1:0] scan_cnt_q;
  logic pv_q;
  logic [AW-1:0] paddr_q;
  logic [15:0] used_q, same_q;
  logic [3:0] sc_cnt_q, best_q, best_d;
  logic signed [5:0] best_sc_q, best_sc_d;

  logic [7:0] m_st_q, m_d1_q, m_d2_q;
  logic m_len3_q;
  logic [7:0] pend_q;
  logic pend_v_q;
  logic out_v_q;
  out_item_t out_q;

  logic in_acc, bad_item, out_free, can_emit, emit, flush_go;
  logic [7:0] emit_byte;
  logic [AW-1:0] raddr;
  logic mem_we;
  logic [3:0] ch_sel;
  logic act;
  logic req, m_len3, fin, go_scan, set_perc;
  logic [7:0] m_st, m_d1, m_d2;
  logic we_vol, we_pat, we_bank, we_bend, we_pan;
  logic [7:0] vol_nv, pan_nv, vol_map;
  logic signed [5:0] score;
  logic skip;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign bad_item   = ({1'b0, in_item_i.source_chan} >= 9'(NUM_SOURCES))
                      || (in_item_i.cmd > CMD_PAN);
  assign cfg_ready_o = 1'b1;

  assign raddr  = (state_q == S_SCAN) ? scan_cnt_q[AW-1:0] : in_item_i.source_chan[AW-1:0];
  assign ch_sel = (state_q == S_SCORE) ? sc_cnt_q : mc_q;
  assign act    = e_q.note != 7'd0 && e_q.chan[4];
  assign vol_map = map_volume(item_q.volume);

  mvcm_src_mem #(.NUM_SOURCES(NUM_SOURCES)) u_src_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (item_q.source_chan[AW-1:0]),
    .wdata_i (e_d),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // command sequencer: one step per cycle in S_EXEC
  always_comb begin
    req = 1'b0; m_st = '0; m_d1 = '0; m_d2 = '0; m_len3 = 1'b1;
    fin = 1'b0; go_scan = 1'b0; set_perc = 1'b0;
    we_vol = 1'b0; we_pat = 1'b0; we_bank = 1'b0; we_bend = 1'b0; we_pan = 1'b0;
    vol_nv = vol_map; pan_nv = e_q.pan;
    e_d = e_q;
    unique case (item_q.cmd)
      CMD_PATCH_BANK: begin
        e_d.bank  = item_q.bank;
        e_d.patch = item_q.patch;
        e_d.pref  = {item_q.pref_lock, item_q.pref_mask};
        fin = 1'b1;
      end
      CMD_KEY_ON, CMD_KEY_OFF: begin
        if (step_q == 3'd0) begin
          if (act) begin
            req  = 1'b1;
            m_st = (running_q == {ST_NOTE_ON, mc_q}) ? {ST_NOTE_ON, mc_q}
                                                    : {ST_NOTE_OFF, mc_q};
            m_d1 = {1'b0, e_q.note};
            e_d.chan = '0;
            e_d.note = '0;
            e_d.pan  = '0;
          end
        end else if (item_q.cmd == CMD_KEY_OFF) begin
          fin = 1'b1;
        end else if (step_q == 3'd1) begin
          if (e_q.patch[7]) begin
            set_perc = 1'b1;
            e_d.chan = {1'b1, PERC_CHAN};
          end else begin
            go_scan = 1'b1;
          end
        end else if (e_q.patch[7]) begin
          case (step_q)
            3'd2: begin
              if (out_pan_q[ch_sel] != e_q.pan) begin
                we_pan = 1'b1; req = 1'b1;
                m_st = {ST_CTRL, mc_q}; m_d1 = CC_PAN; m_d2 = (e_q.pan ^ 8'h80) >> 1;
              end
            end
            3'd3: begin
              if (out_vol_q[ch_sel] != vol_map) begin
                we_vol = 1'b1; req = 1'b1;
                m_st = {ST_CTRL, mc_q}; m_d1 = CC_VOLUME; m_d2 = vol_map;
              end
            end
            3'd4: begin
              e_d.note = e_q.patch[6:0];
              req = 1'b1;
              m_st = {ST_NOTE_ON, mc_q}; m_d1 = {1'b0, e_q.patch[6:0]}; m_d2 = VEL_FULL;
            end
            default: fin = 1'b1;
          endcase
        end else begin
          case (step_q)
            3'd2: begin
              if (out_bank_q[ch_sel] != e_q.bank) begin
                we_bank = 1'b1; req = 1'b1;
                m_st = {ST_CTRL, mc_q}; m_d1 = CC_BANK; m_d2 = e_q.bank;
              end
            end
            3'd3: begin
              if (out_pat_q[ch_sel] != e_q.patch) begin
                we_pat = 1'b1; req = 1'b1; m_len3 = 1'b0;
                m_st = {ST_PROGRAM, mc_q}; m_d1 = e_q.patch;
              end
            end
            3'd4: begin
              if (out_vol_q[ch_sel] != vol_map) begin
                we_vol = 1'b1; req = 1'b1;
                m_st = {ST_CTRL, mc_q}; m_d1 = CC_VOLUME; m_d2 = vol_map;
              end
            end
            3'd5: begin
              e_d.note = item_q.key;
              req = 1'b1;
              m_st = {ST_NOTE_ON, mc_q}; m_d1 = {1'b0, item_q.key}; m_d2 = VEL_FULL;
            end
            3'd6: begin
              if (out_pan_q[ch_sel] != e_q.pan) begin
                we_pan = 1'b1; req = 1'b1;
                m_st = {ST_CTRL, mc_q}; m_d1 = CC_PAN; m_d2 = (e_q.pan ^ 8'h80) >> 1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      CMD_TOUCH: begin
        if (step_q != 3'd0) begin
          fin = 1'b1;
        end else if (act && out_vol_q[ch_sel] != vol_map) begin
          we_vol = 1'b1; req = 1'b1;
          m_st = {ST_CTRL, mc_q}; m_d1 = CC_VOLUME; m_d2 = vol_map;
        end
      end
      CMD_BEND: begin
        if (step_q != 3'd0) begin
          fin = 1'b1;
        end else if (act && out_bend_q[ch_sel] != item_q.bend_value) begin
          we_bend = 1'b1; req = 1'b1;
          m_st = {ST_BEND, mc_q};
          m_d1 = {1'b0, item_q.bend_value[6:0]};
          m_d2 = {1'b0, item_q.bend_value[13:7]};
        end
      end
      CMD_PAN: begin
        if (step_q != 3'd0) begin
          fin = 1'b1;
        end else begin
          e_d.pan = item_q.pan;
          pan_nv  = item_q.pan;
          if (act && out_pan_q[ch_sel] != item_q.pan) begin
            we_pan = 1'b1; req = 1'b1;
            m_st = {ST_CTRL, mc_q}; m_d1 = CC_PAN; m_d2 = (item_q.pan ^ 8'h80) >> 1;
          end
        end
      end
      default: fin = 1'b1;
    endcase
  end

  // channel score for channel sc_cnt_q
  always_comb begin
    score = '0;
    skip  = (sc_cnt_q == PERC_CHAN);
    if (mode_q != MODE_TRY && out_pat_q[ch_sel] != UNKNOWN) begin
      if (out_pat_q[ch_sel] != e_q.patch) score = score - 6'sd4;
      if (out_bank_q[ch_sel] != e_q.bank) score = score - 6'sd6;
    end
    if (mode_q == MODE_TRY) begin
      if (e_q.pref[sc_cnt_q]) score = score + 6'sd1;
    end else if (mode_q == MODE_ALWAYS) begin
      if (e_q.pref[16]) begin
        if (sc_cnt_q != item_q.source_chan[3:0]) skip = 1'b1;
      end else if (!e_q.pref[sc_cnt_q]) begin
        skip = 1'b1;
      end
    end else begin
      if (item_q.source_chan == {4'd0, sc_cnt_q}) score = score + 6'sd1;
    end
    if (same_q[sc_cnt_q]) score = score - 6'sd9;
    if (!used_q[sc_cnt_q]) score = score + 6'sd2;
    best_d    = best_q;
    best_sc_d = best_sc_q;
    if (!skip && score > best_sc_q) begin
      best_d    = sc_cnt_q;
      best_sc_d = score;
    end
  end

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;
  assign emit     = state_q == S_MSG && can_emit;
  assign flush_go = state_q == S_FLUSH && pend_v_q && out_free;
  assign mem_we   = state_q == S_EXEC && fin;

  always_comb begin
    case (phase_q)
      PH_STATUS: emit_byte = m_st_q;
      PH_D1:     emit_byte = m_d1_q;
      default:   emit_byte = m_d2_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && !bad_item) state_d = S_LOAD;
      S_LOAD:  state_d = S_EXEC;
      S_EXEC: begin
        if (fin) state_d = S_FLUSH;
        else if (go_scan) state_d = S_SCAN;
        else if (req && enable_q) state_d = S_MSG;
      end
      S_MSG: begin
        if (emit && (phase_q == PH_D2 || (phase_q == PH_D1 && !m_len3_q))) state_d = S_EXEC;
      end
      S_SCAN:  if (scan_cnt_q == CW'(NUM_SOURCES) && !pv_q) state_d = S_SCORE;
      S_SCORE: if (sc_cnt_q == 4'd15) state_d = S_EXEC;
      S_FLUSH: if (!pend_v_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      enable_q  <= 1'b1;
      mode_q    <= MODE_ALWAYS;
      running_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      pv_q      <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        out_vol_q[i]  <= UNKNOWN;
        out_pat_q[i]  <= UNKNOWN;
        out_bank_q[i] <= UNKNOWN;
        out_bend_q[i] <= BEND_CENTER;
        out_pan_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MIDI_ENABLE) enable_q <= cfg_data_i[0];
        else if (cfg_index_i == CFG_CHANNEL_MODE) mode_q <= cfg_data_i;
      end
      if (state_q == S_EXEC) begin
        if (we_vol)  out_vol_q[mc_q]  <= vol_nv;
        if (we_pat)  out_pat_q[mc_q]  <= e_q.patch;
        if (we_bank) out_bank_q[mc_q] <= e_q.bank;
        if (we_bend) out_bend_q[mc_q] <= item_q.bend_value;
        if (we_pan)  out_pan_q[mc_q]  <= pan_nv;
      end
      if (emit && phase_q == PH_STATUS) running_q <= m_st_q;
      if ((emit && pend_v_q) || flush_go) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (flush_go) begin
        pend_v_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        pv_q <= scan_cnt_q != CW'(NUM_SOURCES);
      end else begin
        pv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
    if (emit) begin
      pend_q <= emit_byte;
      if (pend_v_q) out_q <= '{midi_byte: pend_q, last_byte: 1'b0};
    end
    if (flush_go) out_q <= '{midi_byte: pend_q, last_byte: 1'b1};
    unique case (state_q)
      S_LOAD: begin
        e_q    <= rdata;
        mc_q   <= rdata.chan[3:0];
        step_q <= '0;
      end
      S_EXEC: begin
        e_q    <= e_d;
        step_q <= go_scan ? 3'd2 : step_q + 3'd1;
        if (set_perc) mc_q <= PERC_CHAN;
        if (go_scan) begin
          scan_cnt_q <= '0;
          used_q     <= '0;
          same_q     <= '0;
        end
        m_st_q   <= m_st;
        m_d1_q   <= m_d1;
        m_d2_q   <= m_d2;
        m_len3_q <= m_len3;
        phase_q  <= (m_st == running_q) ? PH_D1 : PH_STATUS;
      end
      S_MSG: begin
        if (emit) begin
          unique case (phase_q)
            PH_STATUS: phase_q <= PH_D1;
            PH_D1:     phase_q <= PH_D2;
            default:   phase_q <= PH_D2;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_cnt_q != CW'(NUM_SOURCES)) begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
          paddr_q    <= scan_cnt_q[AW-1:0];
        end
        if (pv_q && paddr_q != item_q.source_chan[AW-1:0] && rdata.note != 7'd0
            && rdata.chan[4] && !rdata.patch[7]) begin
          used_q[rdata.chan[3:0]] <= 1'b1;
          if (rdata.note == item_q.key) same_q[rdata.chan[3:0]] <= 1'b1;
        end
        sc_cnt_q  <= '0;
        best_q    <= item_q.source_chan[3:0];
        best_sc_q <= SCORE_NONE;
      end
      S_SCORE: begin
        sc_cnt_q  <= sc_cnt_q + 4'd1;
        best_q    <= best_d;
        best_sc_q <= best_sc_d;
        if (sc_cnt_q == 4'd15) begin
          mc_q     <= best_d;
          e_q.chan <= {1'b1, best_d};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("byte held back in idle");
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCORE |-> scan_cnt_q == CW'(NUM_SOURCES)) else $error("scan cut short");
  a_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(running_q) |-> $past(state_q) == S_MSG) else $error("running status moved");
`endif

endmodule
